FILE: rtl/core/epfm_pkg.sv
package epfm_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TIMEOUT = 2'd0;
    localparam logic [1:0] OP_EDGE    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Cycle phase codes
    localparam logic [1:0] PHASE_NONE     = 2'd0;
    localparam logic [1:0] PHASE_STARTED  = 2'd1;
    localparam logic [1:0] PHASE_MEASURED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BUS_CLOCK_HZ       = 2'd0;
    localparam logic [1:0] REG_MAX_INTERVAL       = 2'd1;
    localparam logic [1:0] REG_HIGH_FREQ_INTERVAL = 2'd2;

    // Register reset values
    localparam logic [31:0] BUS_CLOCK_HZ_RESET       = 32'd80000000;
    localparam logic [31:0] MAX_INTERVAL_RESET       = 32'd80000000;
    localparam logic [31:0] HIGH_FREQ_INTERVAL_RESET = 32'd80000;

    localparam int TIMEOUT_BITS = 8;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 8'd255;

    localparam int DATA_BITS = 32;
    localparam int DIV_CNT_BITS = 5;
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST_STEP = 5'd31;

endpackage

FILE: rtl/core/edge_period_frequency_meter.sv
// Flow: an accepted transaction is captured (S_IDLE), its interval formed (S_DIFF), the
//   opcode applied (S_APPLY), a read with a nonzero stored interval divided in the
//   bit-serial divider (S_DIV), and the result loaded in S_DONE. One item at a time:
//   s_ready returns once the result is loaded, and later while m_ready stalls the output.
// Reset: synchronous, active low on aresetn; restores the register defaults, timeout
//   count 255, no edge seen, no stored interval, meter running, and an empty output.
module edge_period_frequency_meter #(
    parameter int COUNT_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [23:0] s_timer_count,

    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frequency,
    output logic [31:0] m_last_interval,
    output logic        m_running,
    output logic [1:0]  m_cycle_status
);

    localparam int STAMP_BITS = COUNT_BITS + epfm_pkg::TIMEOUT_BITS;
    localparam int DW = epfm_pkg::DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_APPLY,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [DW-1:0] bus_clock_hz_reg;
    logic [DW-1:0] max_interval_reg;
    logic [DW-1:0] high_freq_interval_reg;

    // Meter state
    logic [epfm_pkg::TIMEOUT_BITS-1:0] timeout_count_reg;
    logic [STAMP_BITS-1:0]             previous_stamp_reg;
    logic [1:0]                        cycle_phase_reg;
    logic [STAMP_BITS-1:0]             stored_interval_reg;
    logic                              enabled_reg;

    // Working registers of the current item
    logic [1:0]            op_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [STAMP_BITS-1:0] interval_reg;

    // Bit-serial divider: remainder, quotient/dividend shifter and step counter
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   quo_reg;
    logic [epfm_pkg::DIV_CNT_BITS-1:0] div_cnt_reg;

    // Output register
    logic          m_valid_reg;
    logic [DW-1:0] m_frequency_reg;
    logic [DW-1:0] m_last_interval_reg;
    logic          m_running_reg;
    logic [1:0]    m_cycle_status_reg;

    logic                  s_accept;
    logic                  out_free;
    logic [STAMP_BITS-1:0] stamp_in;
    logic [DW:0]           div_shifted;
    logic [DW:0]           div_diff;
    logic                  div_bit;
    logic [DW-1:0]         div_rem_step;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Stamp: timeout count above the captured down-count, before any decrement
    assign stamp_in = {timeout_count_reg, s_timer_count[COUNT_BITS-1:0]};

    // One restoring division step: shift in the next dividend bit, trial subtract
    always_comb begin
        div_shifted  = {rem_reg, quo_reg[DW-1]};
        div_diff     = div_shifted - {1'b0, DW'(stored_interval_reg)};
        div_bit      = !div_diff[DW];
        div_rem_step = div_bit ? div_diff[DW-1:0] : div_shifted[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= S_IDLE;
            bus_clock_hz_reg       <= epfm_pkg::BUS_CLOCK_HZ_RESET;
            max_interval_reg       <= epfm_pkg::MAX_INTERVAL_RESET;
            high_freq_interval_reg <= epfm_pkg::HIGH_FREQ_INTERVAL_RESET;
            timeout_count_reg      <= epfm_pkg::TIMEOUT_RESET;
            previous_stamp_reg     <= '0;
            cycle_phase_reg        <= epfm_pkg::PHASE_NONE;
            stored_interval_reg    <= '0;
            enabled_reg            <= 1'b1;
            div_cnt_reg            <= '0;
            m_valid_reg            <= 1'b0;
        end else begin
            // Configuration writes land at once; unknown indexes drop
            if (cfg_we) begin
                case (cfg_index)
                    epfm_pkg::REG_BUS_CLOCK_HZ:       bus_clock_hz_reg <= cfg_data;
                    epfm_pkg::REG_MAX_INTERVAL:       max_interval_reg <= cfg_data;
                    epfm_pkg::REG_HIGH_FREQ_INTERVAL: high_freq_interval_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Drain the output register when the consumer takes it
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    // Capture the transaction and its stamp
                    if (s_accept) begin
                        op_reg    <= s_opcode;
                        stamp_reg <= stamp_in;
                        state_reg <= S_DIFF;
                    end
                end

                S_DIFF: begin
                    // Interval since the previous edge, modulo the stamp width
                    interval_reg <= previous_stamp_reg - stamp_reg;
                    state_reg    <= S_APPLY;
                end

                S_APPLY: begin
                    quo_reg     <= '0;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DONE;
                    case (op_reg)
                        epfm_pkg::OP_TIMEOUT: begin
                            if (enabled_reg) begin
                                timeout_count_reg <= timeout_count_reg - 1'b1;
                                // Signal lost: clear the interval and stop
                                if (DW'(interval_reg) > max_interval_reg) begin
                                    stored_interval_reg <= '0;
                                    enabled_reg         <= 1'b0;
                                end
                            end
                        end
                        epfm_pkg::OP_EDGE: begin
                            if (enabled_reg) begin
                                if (cycle_phase_reg == epfm_pkg::PHASE_NONE) begin
                                    cycle_phase_reg <= epfm_pkg::PHASE_STARTED;
                                end else begin
                                    stored_interval_reg <= interval_reg;
                                    cycle_phase_reg     <= epfm_pkg::PHASE_MEASURED;
                                    // Too fast to follow: stop the meter
                                    if (DW'(interval_reg) < high_freq_interval_reg) begin
                                        enabled_reg <= 1'b0;
                                    end
                                end
                                previous_stamp_reg <= stamp_reg;
                            end
                        end
                        epfm_pkg::OP_READ: begin
                            // Load the dividend; skip the divider on a zero interval
                            if (stored_interval_reg != '0) begin
                                quo_reg   <= bus_clock_hz_reg;
                                state_reg <= S_DIV;
                            end
                            // Restart a stopped meter; the stored interval is kept
                            if (!enabled_reg) begin
                                timeout_count_reg  <= epfm_pkg::TIMEOUT_RESET;
                                previous_stamp_reg <= '0;
                                cycle_phase_reg    <= epfm_pkg::PHASE_NONE;
                                enabled_reg        <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end

                S_DIV: begin
                    // Advance one quotient bit per cycle
                    rem_reg     <= div_rem_step;
                    quo_reg     <= {quo_reg[DW-2:0], div_bit};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == epfm_pkg::DIV_LAST_STEP) begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free, then load the result
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_frequency_reg     <= quo_reg;
                        m_last_interval_reg <= DW'(stored_interval_reg);
                        m_running_reg       <= enabled_reg;
                        m_cycle_status_reg  <= cycle_phase_reg;
                        state_reg           <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_frequency     = m_frequency_reg;
    assign m_last_interval = m_last_interval_reg;
    assign m_running       = m_running_reg;
    assign m_cycle_status  = m_cycle_status_reg;

    // A nonzero frequency always comes from a nonzero stored interval
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frequency != '0) |-> (m_last_interval != '0))
    else $error("nonzero frequency reported with no stored interval");

    // The divider only runs on a nonzero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (stored_interval_reg != '0))
    else $error("divider running with a zero interval");

    // An accepted transaction keeps the input closed in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
    else $error("input ready right after an accepted transaction");

    // A result never loads over one that the consumer has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
    else $error("pending result dropped");

endmodule
